// ===== rtl/core/i2cm_pkg.sv =====
// Shared types and constants for the I2C register-access master.
// Used by every module under rtl/core; depends on nothing.
package i2cm_pkg;

    localparam int unsigned DEV_ADDR_W  = 7;
    localparam int unsigned PHASE_W     = 10;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned BIT_IDX_W   = 4;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 10;
    localparam int unsigned S_TDATA_W   = 32;
    localparam int unsigned M_TDATA_W   = 16;

    localparam logic [BIT_IDX_W-1:0] LAST_DATA_BIT = BIT_IDX_W'(7);
    localparam logic [BIT_IDX_W-1:0] ACK_BIT       = BIT_IDX_W'(8);
    localparam logic [PHASE_W-1:0]   PHASE_RESET   = PHASE_W'(5);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS    = 1'b1;

    // transaction kinds
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // bus sequencer states
    typedef enum logic [8:0] {
        ST_IDLE       = 9'b0_0000_0001,
        ST_RS_LOW     = 9'b0_0000_0010,
        ST_START_HIGH = 9'b0_0000_0100,
        ST_START_HOLD = 9'b0_0000_1000,
        ST_BIT_LOW    = 9'b0_0001_0000,
        ST_BIT_HIGH   = 9'b0_0010_0000,
        ST_STOP_LOW   = 9'b0_0100_0000,
        ST_STOP_HIGH  = 9'b0_1000_0000,
        ST_STOP_HOLD  = 9'b1_0000_0000
    } t_step;

    // which byte is on the bus
    typedef enum logic [4:0] {
        FR_ADDR_W = 5'b00001,
        FR_REG    = 5'b00010,
        FR_WDATA  = 5'b00100,
        FR_ADDR_R = 5'b01000,
        FR_RDATA  = 5'b10000
    } t_frame;

    typedef struct packed {
        t_step                 step;
        t_frame                frame;
        logic [PHASE_W-1:0]    phase_timer;
        logic [BIT_IDX_W-1:0]  bit_index;
        logic [BYTE_W-1:0]     bytes_left;
        logic [BYTE_W-1:0]     shift_byte;
        logic                  latched_op;
        logic [BYTE_W-1:0]     latched_register;
        logic                  ack_failed;
    } t_state;

    typedef struct packed {
        logic [DEV_ADDR_W-1:0] device_address;
        logic [PHASE_W-1:0]    phase_ticks;
    } t_cfg;

    // one tick request
    typedef struct packed {
        logic              go;
        logic              op;
        logic [BYTE_W-1:0] register_addr;
        logic [BYTE_W-1:0] byte_count;
        logic [BYTE_W-1:0] write_byte;
        logic              sda_in;
    } t_item;

    // one tick result
    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              sda_enable;
        logic              busy_res;
        logic              data_taken;
        logic [BYTE_W-1:0] read_byte;
        logic              read_valid;
        logic              read_last;
        logic              done_res;
        logic              nack_error;
    } t_result;

endpackage

// ===== rtl/core/i2cm_step.sv =====
// Next-state and bus-output logic of the I2C master for one tick.
// Depends on i2cm_pkg.
module i2cm_step
    import i2cm_pkg::*;
(
    input  t_state  i_state,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    output t_state  o_next,
    output t_result o_res
);

    logic [PHASE_W-1:0] plen;
    logic               phase_end;
    logic               last_byte;
    logic [BYTE_W-1:0]  bytes_dec;
    logic [BYTE_W-1:0]  shifted;
    logic               begin_f;
    t_frame             begin_target;

    assign plen      = (i_cfg.phase_ticks == '0) ? PHASE_W'(1) : i_cfg.phase_ticks;
    assign phase_end = ({1'b0, i_state.phase_timer} + (PHASE_W+1)'(1)) >= {1'b0, plen};
    assign last_byte = (i_state.bytes_left <= BYTE_W'(1));
    assign bytes_dec = (i_state.bytes_left == '0) ? '0 : i_state.bytes_left - BYTE_W'(1);
    assign shifted   = {i_state.shift_byte[BYTE_W-2:0], i_item.sda_in};

    // bus levels reflect the state at the start of the tick
    always_comb begin
        o_res = '0;
        o_res.scl_level = 1'b1;
        o_res.sda_level = 1'b1;
        o_res.busy_res  = 1'b1;
        unique case (i_state.step)
            ST_RS_LOW: begin
                o_res.scl_level  = 1'b0;
                o_res.sda_enable = 1'b1;
            end
            ST_START_HIGH: begin
                o_res.sda_enable = 1'b1;
            end
            ST_START_HOLD: begin
                o_res.sda_enable = 1'b1;
                o_res.sda_level  = 1'b0;
            end
            ST_BIT_LOW, ST_BIT_HIGH: begin
                o_res.scl_level = (i_state.step == ST_BIT_HIGH);
                if (i_state.bit_index < ACK_BIT) begin
                    if (i_state.frame != FR_RDATA) begin
                        o_res.sda_enable = 1'b1;
                        o_res.sda_level  = i_state.shift_byte[BYTE_W-1];
                    end
                end else if (i_state.frame == FR_RDATA) begin
                    // master ACK, NACK on the final byte
                    o_res.sda_enable = 1'b1;
                    o_res.sda_level  = last_byte;
                end
            end
            ST_STOP_LOW: begin
                o_res.scl_level  = 1'b0;
                o_res.sda_enable = 1'b1;
                o_res.sda_level  = 1'b0;
            end
            ST_STOP_HIGH: begin
                o_res.sda_enable = 1'b1;
                o_res.sda_level  = 1'b0;
            end
            ST_STOP_HOLD: begin
                o_res.sda_enable = 1'b1;
            end
            default: begin
                o_res.busy_res = 1'b0;
            end
        endcase

        o_next       = i_state;
        begin_f      = 1'b0;
        begin_target = i_state.frame;

        if (i_state.step == ST_IDLE || !$onehot(i_state.step)) begin
            o_next.step        = ST_IDLE;
            o_next.phase_timer = '0;
            if (i_item.go) begin
                o_next.latched_op       = i_item.op;
                o_next.latched_register = i_item.register_addr;
                o_next.bytes_left       = (i_item.byte_count == '0) ? BYTE_W'(1)
                                                                    : i_item.byte_count;
                o_next.ack_failed       = 1'b0;
                o_next.frame            = FR_ADDR_W;
                o_next.bit_index        = '0;
                o_next.step             = ST_START_HIGH;
            end
        end else if (!phase_end) begin
            o_next.phase_timer = i_state.phase_timer + PHASE_W'(1);
        end else begin
            o_next.phase_timer = '0;
            unique case (i_state.step)
                ST_RS_LOW:     o_next.step = ST_START_HIGH;
                ST_START_HIGH: o_next.step = ST_START_HOLD;
                ST_START_HOLD: begin_f = 1'b1;
                ST_BIT_LOW:    o_next.step = ST_BIT_HIGH;
                ST_BIT_HIGH: begin
                    if (i_state.bit_index < ACK_BIT) begin
                        o_next.shift_byte = shifted;
                        if (i_state.frame == FR_RDATA && i_state.bit_index == LAST_DATA_BIT) begin
                            o_res.read_byte  = shifted;
                            o_res.read_valid = 1'b1;
                            o_res.read_last  = last_byte;
                        end
                        o_next.bit_index = i_state.bit_index + BIT_IDX_W'(1);
                        o_next.step      = ST_BIT_LOW;
                    end else if (i_state.frame == FR_RDATA) begin
                        o_next.bytes_left = bytes_dec;
                        if (last_byte) begin
                            o_next.step = ST_STOP_LOW;
                        end else begin
                            begin_f      = 1'b1;
                            begin_target = FR_RDATA;
                        end
                    end else if (i_item.sda_in) begin
                        // missing ACK: abort through a stop
                        o_next.ack_failed = 1'b1;
                        o_next.step       = ST_STOP_LOW;
                    end else if (i_state.frame == FR_ADDR_W) begin
                        begin_f      = 1'b1;
                        begin_target = FR_REG;
                    end else if (i_state.frame == FR_REG) begin
                        if (i_state.latched_op == OP_WRITE) begin
                            begin_f      = 1'b1;
                            begin_target = FR_WDATA;
                        end else begin
                            o_next.frame     = FR_ADDR_R;
                            o_next.bit_index = '0;
                            o_next.step      = ST_RS_LOW;
                        end
                    end else if (i_state.frame == FR_ADDR_R) begin
                        begin_f      = 1'b1;
                        begin_target = FR_RDATA;
                    end else begin
                        o_next.bytes_left = bytes_dec;
                        if (last_byte) begin
                            o_next.step = ST_STOP_LOW;
                        end else begin
                            begin_f      = 1'b1;
                            begin_target = FR_WDATA;
                        end
                    end
                end
                ST_STOP_LOW:  o_next.step = ST_STOP_HIGH;
                ST_STOP_HIGH: o_next.step = ST_STOP_HOLD;
                default: begin
                    o_res.done_res   = 1'b1;
                    o_res.nack_error = i_state.ack_failed;
                    o_next.step      = ST_IDLE;
                end
            endcase
        end

        // load the next byte onto the bus
        if (begin_f) begin
            o_next.frame     = begin_target;
            o_next.bit_index = '0;
            o_next.step      = ST_BIT_LOW;
            unique case (begin_target)
                FR_ADDR_W: o_next.shift_byte = {i_cfg.device_address, 1'b0};
                FR_ADDR_R: o_next.shift_byte = {i_cfg.device_address, 1'b1};
                FR_REG:    o_next.shift_byte = i_state.latched_register;
                FR_WDATA: begin
                    o_next.shift_byte = i_item.write_byte;
                    o_res.data_taken  = 1'b1;
                end
                default:   o_next.shift_byte = '0;
            endcase
        end
    end

endmodule

// ===== rtl/core/i2cm_core.sv =====
// Input register, configuration registers and sequencer state of the I2C master.
// Depends on i2cm_pkg and i2cm_step.
module i2cm_core
    import i2cm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_item                 i_item,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output t_result               o_res
);

    logic    r_in_valid;
    t_item   r_in;
    t_state  r_state;
    t_state  n_state;
    t_cfg    r_cfg;
    logic    advance;

    assign advance     = r_in_valid && i_res_ready;
    assign o_ready     = !r_in_valid || i_res_ready;
    assign o_res_valid = r_in_valid;

    i2cm_step u_step (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_item  (r_in),
        .o_next  (n_state),
        .o_res   (o_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.step             <= ST_IDLE;
            r_state.frame            <= FR_ADDR_W;
            r_state.phase_timer      <= '0;
            r_state.bit_index        <= '0;
            r_state.bytes_left       <= '0;
            r_state.shift_byte       <= '0;
            r_state.latched_op       <= 1'b0;
            r_state.latched_register <= '0;
            r_state.ack_failed       <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address <= '0;
            r_cfg.phase_ticks    <= PHASE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEVICE_ADDRESS: r_cfg.device_address <= i_cfg_data[DEV_ADDR_W-1:0];
                CFG_PHASE_TICKS:    r_cfg.phase_ticks    <= i_cfg_data[PHASE_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/core/i2cm_skid.sv =====
// Output register with a skid stage for the tick results.
// Depends on i2cm_pkg.
module i2cm_skid
    import i2cm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_res,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    push;

    assign o_ready = !r_skid_valid;
    assign push    = i_valid && !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            r_out_valid  <= r_skid_valid || push;
            r_skid_valid <= 1'b0;
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (push) begin
            r_skid <= i_res;
        end
    end

endmodule

// ===== rtl/core/i2c_master_register_access.sv =====
// Top level of the tick-driven I2C master for register writes and reads.
// Depends on i2cm_pkg, i2cm_core and i2cm_skid.
//
// Every request on the s_axis channel is one timing tick. It carries the go
// flag and transaction fields (op travels in tuser) plus the sampled SDA level.
// The master answers every request with exactly one result on m_axis: the SCL
// and SDA drive levels, busy, the data_taken strobe, any completed read byte
// (tlast marks the final byte of a read), and done with its NACK flag.
// A go is taken only while idle. The transaction runs start, device address
// with write, register address, then either the data bytes or a repeated
// start, address with read and the read bytes, and always closes with a stop.
// Each SCL phase lasts phase_ticks requests (one request when it is 0).
// A request lands in the input register at its accepting edge; its result is
// then loaded into the output register, or into the skid stage while the
// receiver stalls. Throughput is one request per cycle while the receiver
// keeps up, set by the combinational sequencer step between the registers.
// When the receiver stalls, the output register holds and one more result
// drops into the skid stage; s_axis_tready then falls until space frees.
// Reset (synchronous, active low) returns the sequencer to idle, empties both
// stages and sets device_address to 0 and phase_ticks to 5.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data.
module i2c_master_register_access
    import i2cm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // go[0], register_addr[8:1], byte_count[16:9], write_byte[24:17],
    // sda_in[25], zero fill[31:26]
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // op[0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // scl_level[0], sda_level[1], sda_enable[2], busy_res[3], data_taken[4],
    // read_byte[12:5], read_valid[13], done_res[14], nack_error[15]
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // read_last
    output logic                  m_axis_tlast
);

    t_item   in_item;
    t_result core_res;
    t_result out_res;
    logic    core_valid;
    logic    core_ready;

    // unpack the request
    assign in_item.go            = s_axis_tdata[0];
    assign in_item.op            = s_axis_tuser;
    assign in_item.register_addr = s_axis_tdata[8:1];
    assign in_item.byte_count    = s_axis_tdata[16:9];
    assign in_item.write_byte    = s_axis_tdata[24:17];
    assign in_item.sda_in        = s_axis_tdata[25];

    i2cm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_item      (in_item),
        .o_res_valid (core_valid),
        .i_res_ready (core_ready),
        .o_res       (core_res)
    );

    i2cm_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (core_valid),
        .o_ready (core_ready),
        .i_res   (core_res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    // pack the result
    assign m_axis_tdata = {out_res.nack_error, out_res.done_res, out_res.read_valid,
                           out_res.read_byte, out_res.data_taken, out_res.busy_res,
                           out_res.sda_enable, out_res.sda_level, out_res.scl_level};
    assign m_axis_tlast = out_res.read_last;

    // a full skid stage means the output register is occupied
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !core_ready |-> m_axis_tvalid)
        else $error("skid stage holds a result while the output register is empty");

    // tlast only marks a completed read byte
    a_last_with_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[13])
        else $error("read_last without read_valid");

    // a read byte never shares a tick with a write strobe or done
    a_read_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[13] |-> !m_axis_tdata[4] && !m_axis_tdata[14])
        else $error("read_valid together with data_taken or done");

    // nack is reported only with done, and done only while busy
    a_nack_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[15] || m_axis_tdata[14])
            |-> m_axis_tdata[14] && m_axis_tdata[3])
        else $error("nack_error outside done, or done while not busy");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for the I2C register-access master: drives timing-tick
// requests, predicts each result in a tracker class and compares field by field.
// Depends on i2cm_pkg and i2c_master_register_access.
`timescale 1ns / 100ps

module tb_top;
    import i2cm_pkg::*;

    localparam int STALL_LIMIT  = 1000;  // cycles without any handshake
    localparam int NACK_NONE    = -1;    // never NACK an ACK slot
    localparam int NACK_RANDOM  = -2;    // NACK ACK slots now and then

    // Tracks the bus sequencer tick by tick and holds the levels still owed.
    class t_bus_tracker;
        logic [DEV_ADDR_W-1:0] dev_addr;
        logic [PHASE_W-1:0]    ticks;
        t_step                 step;
        t_frame                frm;
        int unsigned           tmr;
        logic [BIT_IDX_W-1:0]  bit_no;
        logic [BYTE_W-1:0]     left;
        logic [BYTE_W-1:0]     shreg;
        logic                  rd_op;
        logic [BYTE_W-1:0]     reg_lat;
        logic                  nacked;
        t_result               levels_due[$];
        int                    mismatches;
        int                    results_matched;

        function new();
            dev_addr        = '0;
            ticks           = PHASE_RESET;
            step            = ST_IDLE;
            frm             = FR_ADDR_W;
            tmr             = 0;
            bit_no          = '0;
            left            = '0;
            shreg           = '0;
            rd_op           = OP_WRITE;
            reg_lat         = '0;
            nacked          = 1'b0;
            mismatches      = 0;
            results_matched = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DEVICE_ADDRESS: dev_addr = val[DEV_ADDR_W-1:0];
                CFG_PHASE_TICKS:    ticks    = val[PHASE_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned phase_len();
            return (ticks == 0) ? 1 : ticks;
        endfunction

        function bit is_idle();
            return step == ST_IDLE;
        endfunction

        // last tick of a high phase in a slot where the device must ACK
        function bit at_ack_sample();
            return step == ST_BIT_HIGH && bit_no == ACK_BIT && frm != FR_RDATA
                && tmr + 1 >= phase_len();
        endfunction

        function int pending();
            return levels_due.size();
        endfunction

        // Put the next byte on the shifter; returns 1 when write data is taken.
        function logic load_frame(t_frame f, logic [BYTE_W-1:0] wb);
            logic took;
            took   = 1'b0;
            frm    = f;
            bit_no = '0;
            step   = ST_BIT_LOW;
            case (f)
                FR_ADDR_W: shreg = {dev_addr, 1'b0};
                FR_ADDR_R: shreg = {dev_addr, 1'b1};
                FR_REG:    shreg = reg_lat;
                FR_WDATA: begin
                    shreg = wb;
                    took  = 1'b1;
                end
                default:   shreg = '0;
            endcase
            return took;
        endfunction

        function t_result step_sequencer(t_item it);
            t_result r;
            r           = '0;
            r.scl_level = 1'b1;
            r.sda_level = 1'b1;
            r.busy_res  = 1'b1;

            // levels reflect the state at the start of the tick
            case (step)
                ST_RS_LOW: begin
                    r.scl_level  = 1'b0;
                    r.sda_enable = 1'b1;
                end
                ST_START_HIGH: r.sda_enable = 1'b1;
                ST_START_HOLD: begin
                    r.sda_enable = 1'b1;
                    r.sda_level  = 1'b0;
                end
                ST_BIT_LOW, ST_BIT_HIGH: begin
                    r.scl_level = (step == ST_BIT_HIGH);
                    if (bit_no < ACK_BIT) begin
                        if (frm != FR_RDATA) begin
                            r.sda_enable = 1'b1;
                            r.sda_level  = shreg[BYTE_W-1];
                        end
                    end else if (frm == FR_RDATA) begin
                        // master ACKs every read byte but NACKs the last
                        r.sda_enable = 1'b1;
                        r.sda_level  = (left <= 1);
                    end
                end
                ST_STOP_LOW: begin
                    r.scl_level  = 1'b0;
                    r.sda_enable = 1'b1;
                    r.sda_level  = 1'b0;
                end
                ST_STOP_HIGH: begin
                    r.sda_enable = 1'b1;
                    r.sda_level  = 1'b0;
                end
                ST_STOP_HOLD: r.sda_enable = 1'b1;
                default: r.busy_res = 1'b0;
            endcase

            if (step == ST_IDLE) begin
                tmr = 0;
                if (it.go) begin
                    rd_op   = it.op;
                    reg_lat = it.register_addr;
                    left    = (it.byte_count == 0) ? 8'd1 : it.byte_count;
                    nacked  = 1'b0;
                    frm     = FR_ADDR_W;
                    bit_no  = '0;
                    step    = ST_START_HIGH;
                end
            end else if (tmr + 1 < phase_len()) begin
                tmr = tmr + 1;
            end else begin
                tmr = 0;
                case (step)
                    ST_RS_LOW:     step = ST_START_HIGH;
                    ST_START_HIGH: step = ST_START_HOLD;
                    ST_START_HOLD: r.data_taken = load_frame(frm, it.write_byte);
                    ST_BIT_LOW:    step = ST_BIT_HIGH;
                    ST_BIT_HIGH: begin
                        if (bit_no < ACK_BIT) begin
                            shreg = {shreg[BYTE_W-2:0], it.sda_in};
                            if (frm == FR_RDATA && bit_no == LAST_DATA_BIT) begin
                                r.read_byte  = shreg;
                                r.read_valid = 1'b1;
                                r.read_last  = (left <= 1);
                            end
                            bit_no = bit_no + 1'b1;
                            step   = ST_BIT_LOW;
                        end else if (frm == FR_RDATA) begin
                            if (left != 0) left = left - 1'b1;
                            if (left == 0) step = ST_STOP_LOW;
                            else void'(load_frame(FR_RDATA, it.write_byte));
                        end else if (it.sda_in) begin
                            // missing ACK: abort straight into the stop
                            nacked = 1'b1;
                            step   = ST_STOP_LOW;
                        end else if (frm == FR_ADDR_W) begin
                            void'(load_frame(FR_REG, it.write_byte));
                        end else if (frm == FR_REG) begin
                            if (rd_op == OP_WRITE) begin
                                r.data_taken = load_frame(FR_WDATA, it.write_byte);
                            end else begin
                                frm    = FR_ADDR_R;
                                bit_no = '0;
                                step   = ST_RS_LOW;
                            end
                        end else if (frm == FR_ADDR_R) begin
                            void'(load_frame(FR_RDATA, it.write_byte));
                        end else begin
                            if (left != 0) left = left - 1'b1;
                            if (left == 0) step = ST_STOP_LOW;
                            else r.data_taken = load_frame(FR_WDATA, it.write_byte);
                        end
                    end
                    ST_STOP_LOW:  step = ST_STOP_HIGH;
                    ST_STOP_HIGH: step = ST_STOP_HOLD;
                    default: begin
                        r.done_res   = 1'b1;
                        r.nack_error = nacked;
                        step         = ST_IDLE;
                    end
                endcase
            end
            return r;
        endfunction

        function void take_request(t_item it);
            levels_due.push_back(step_sequencer(it));
        endfunction

        task flag_mismatch(string what, int unsigned got, int unsigned want);
            mismatches++;
            $display("[%0t] result %0d: %s got %0h want %0h",
                     $realtime, results_matched, what, got, want);
        endtask

        task match_result(t_result got);
            t_result want;
            if (levels_due.size() == 0) begin
                flag_mismatch("unexpected result", got, 0);
                return;
            end
            want = levels_due.pop_front();
            if (got.scl_level !== want.scl_level)
                flag_mismatch("scl_level", got.scl_level, want.scl_level);
            if (got.sda_level !== want.sda_level)
                flag_mismatch("sda_level", got.sda_level, want.sda_level);
            if (got.sda_enable !== want.sda_enable)
                flag_mismatch("sda_enable", got.sda_enable, want.sda_enable);
            if (got.busy_res !== want.busy_res)
                flag_mismatch("busy_res", got.busy_res, want.busy_res);
            if (got.data_taken !== want.data_taken)
                flag_mismatch("data_taken", got.data_taken, want.data_taken);
            if (got.read_byte !== want.read_byte)
                flag_mismatch("read_byte", got.read_byte, want.read_byte);
            if (got.read_valid !== want.read_valid)
                flag_mismatch("read_valid", got.read_valid, want.read_valid);
            if (got.read_last !== want.read_last)
                flag_mismatch("read_last", got.read_last, want.read_last);
            if (got.done_res !== want.done_res)
                flag_mismatch("done_res", got.done_res, want.done_res);
            if (got.nack_error !== want.nack_error)
                flag_mismatch("nack_error", got.nack_error, want.nack_error);
            results_matched++;
        endtask
    endclass

    // one directed transaction: which ACK slot (0 = device address) gets a NACK
    typedef struct {
        logic              op;
        logic [BYTE_W-1:0] reg_addr;
        logic [BYTE_W-1:0] count;
        int                nack_slot;
    } t_txn_plan;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  s_axis_tvalid  = 1'b0;
    logic                  s_axis_tready;
    // go[0], register_addr[8:1], byte_count[16:9], write_byte[24:17], sda_in[25]
    logic [S_TDATA_W-1:0]  s_axis_tdata   = '0;
    // op[0]
    logic                  s_axis_tuser   = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready  = 1'b0;
    // scl_level[0], sda_level[1], sda_enable[2], busy_res[3], data_taken[4],
    // read_byte[12:5], read_valid[13], done_res[14], nack_error[15]
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    // read_last[0]
    logic                  m_axis_tlast;

    t_bus_tracker   bus;
    t_txn_plan      pending_txns[$];
    int             nack_slot        = NACK_NONE;
    int             ack_slots        = 0;
    bit             random_go        = 1'b0;
    int             send_idle_pct    = 0;
    int             recv_idle_pct    = 0;
    int             recv_hold_cycles = 0;
    int             quiet_cycles     = 0;
    t_result        seen_levels;

    i2c_master_register_access DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Build the next tick request from the tracker's current state. Fields are
    // random on every tick; go while idle starts either a planned transaction
    // or a random one, and ACK slots mostly see a proper ACK so that
    // transactions get past the address bytes.
    function automatic t_item next_tick();
        t_item     it;
        t_txn_plan plan;
        it.go            = ($urandom_range(99) < 3);  // go while busy is ignored
        it.op            = 1'($urandom_range(1));
        it.register_addr = BYTE_W'($urandom_range(255));
        it.byte_count    = BYTE_W'($urandom_range(255));
        it.write_byte    = BYTE_W'($urandom_range(255));
        it.sda_in        = 1'($urandom_range(1));
        if (bus.is_idle()) begin
            it.go = 1'b0;
            if (pending_txns.size() != 0) begin
                plan             = pending_txns.pop_front();
                it.go            = 1'b1;
                it.op            = plan.op;
                it.register_addr = plan.reg_addr;
                it.byte_count    = plan.count;
                nack_slot        = plan.nack_slot;
            end else if (random_go && $urandom_range(99) < 30) begin
                it.go = 1'b1;
                // keep most transactions short; the rest use the full count range
                if ($urandom_range(99) < 85)
                    it.byte_count = BYTE_W'($urandom_range(4));
                nack_slot = NACK_RANDOM;
            end
            if (it.go)
                ack_slots = 0;
        end else if (bus.at_ack_sample()) begin
            it.sda_in = (nack_slot == ack_slots)
                     || (nack_slot == NACK_RANDOM && $urandom_range(99) < 6);
            ack_slots++;
        end
        return it;
    endfunction

    // Offer one request and hold it until the block accepts it.
    task automatic send_tick();
        t_item it;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        it = next_tick();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, it.sda_in, it.write_byte, it.byte_count,
                          it.register_addr, it.go};
        s_axis_tuser  <= it.op;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        bus.take_request(it);
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (bus.pending() != 0)
            @(posedge i_clk);
    endtask

    // Write both registers; only called with the block drained.
    task automatic reconfigure(logic [DEV_ADDR_W-1:0] dev, logic [PHASE_W-1:0] ticks);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DEVICE_ADDRESS;
        i_cfg_data  <= CFG_DATA_W'(dev);
        @(posedge i_clk);
        bus.set_register(CFG_DEVICE_ADDRESS, CFG_DATA_W'(dev));
        i_cfg_index <= CFG_PHASE_TICKS;
        i_cfg_data  <= CFG_DATA_W'(ticks);
        @(posedge i_clk);
        bus.set_register(CFG_PHASE_TICKS, CFG_DATA_W'(ticks));
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_random(int count);
        random_go = 1'b1;
        repeat (count) send_tick();
    endtask

    task automatic plan_txn(logic op, logic [BYTE_W-1:0] reg_addr,
                            logic [BYTE_W-1:0] count, int nack_at);
        t_txn_plan plan;
        plan.op        = op;
        plan.reg_addr  = reg_addr;
        plan.count     = count;
        plan.nack_slot = nack_at;
        pending_txns.push_back(plan);
    endtask

    // Receiver: random backpressure, or a long hold-off when asked for one.
    initial begin
        forever begin
            @(posedge i_clk);
            if (recv_hold_cycles != 0) begin
                m_axis_tready <= 1'b0;
                repeat (recv_hold_cycles) @(posedge i_clk);
                recv_hold_cycles = 0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_levels.scl_level  = m_axis_tdata[0];
            seen_levels.sda_level  = m_axis_tdata[1];
            seen_levels.sda_enable = m_axis_tdata[2];
            seen_levels.busy_res   = m_axis_tdata[3];
            seen_levels.data_taken = m_axis_tdata[4];
            seen_levels.read_byte  = m_axis_tdata[12:5];
            seen_levels.read_valid = m_axis_tdata[13];
            seen_levels.done_res   = m_axis_tdata[14];
            seen_levels.nack_error = m_axis_tdata[15];
            seen_levels.read_last  = m_axis_tlast;
            bus.match_result(seen_levels);
        end
    end

    // Watchdog: end the run when no handshake happens on either side for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        bus = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed transactions at the fastest bus speed and the top address.
        send_idle_pct = 19;
        recv_idle_pct = 19;
        reconfigure(7'h7F, 10'd1);
        plan_txn(OP_WRITE, 8'hFF, 8'd0,   NACK_NONE);  // zero count saturates to one
        plan_txn(OP_READ,  8'h00, 8'd2,   NACK_NONE);  // ACK then NACK on last byte
        plan_txn(OP_WRITE, 8'h5A, 8'd1,   0);          // device address not acknowledged
        plan_txn(OP_READ,  8'hA5, 8'd3,   1);          // register address not acknowledged
        plan_txn(OP_WRITE, 8'h3C, 8'd3,   3);          // second data byte refused
        plan_txn(OP_READ,  8'h81, 8'd1,   2);          // read address not acknowledged
        plan_txn(OP_WRITE, 8'h00, 8'd255, 4);          // full count, cut short by a NACK
        while (pending_txns.size() != 0 || !bus.is_idle())
            send_tick();
        drain_results();

        // Random traffic; partway through, hold the receiver off long enough
        // that the output stages fill and the block stalls its input.
        reconfigure(DEV_ADDR_W'($urandom_range(127)), 10'd1);
        run_random(150);
        recv_hold_cycles = 60;
        run_random(250);
        drain_results();

        // Long stretch without idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        reconfigure(7'h00, 10'd2);
        run_random(300);
        drain_results();

        send_idle_pct = 19;
        recv_idle_pct = 19;
        reconfigure(DEV_ADDR_W'($urandom_range(127)), 10'd3);
        run_random(300);
        drain_results();

        // Zero phase length behaves as one tick per phase.
        reconfigure(DEV_ADDR_W'($urandom_range(127)), 10'd0);
        run_random(150);
        drain_results();

        // Slowest bus; the transaction in flight carries over into the next
        // setting, where the shorter phase ends at once.
        reconfigure(7'h55, 10'd1023);
        run_random(150);
        drain_results();
        reconfigure(7'h2A, 10'd1);
        run_random(200);
        drain_results();

        repeat (4) @(posedge i_clk);
        if (bus.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
